@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, disabled while reset is high.
`define CHECK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CHECK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CHECK_RST(label, clk, rst, prop, msg)
`define CHECK_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ src/dmxrgb_pkg.sv @@
// Types, codes and level arithmetic for the DMX slot capture / RGB PWM block.
package dmxrgb_pkg;

  localparam int NUM_COLOURS = 3;
  localparam int LEVEL_W     = 8;
  localparam int SLOT_W      = 10;
  localparam int BASE_W      = 9;
  localparam int CFG_W       = 9;
  localparam int FIELD_W     = 3;

  localparam logic [SLOT_W-1:0]  SLOT_MAX    = 10'd1023;
  localparam logic [LEVEL_W-1:0] MANUAL_STEP = 8'd36;
  localparam logic [LEVEL_W-1:0] FULL_MASTER = 8'd255;

  // command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_BASE_ADDRESS = 1'b0;
  localparam cfg_index_t REG_DMX_MODE     = 1'b1;

  typedef logic [NUM_COLOURS-1:0][LEVEL_W-1:0] level_arr_t;

  typedef struct packed {
    logic               command;
    logic [LEVEL_W-1:0] data_byte;
    logic               break_flag;
  } item_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic set_updated;
  } result_t;

  // (master * colour) >> 8
  function automatic logic [LEVEL_W-1:0] scale_level(input logic [LEVEL_W-1:0] master,
                                                     input logic [LEVEL_W-1:0] colour);
    logic [2*LEVEL_W-1:0] prod;
    prod = (2*LEVEL_W)'(master) * (2*LEVEL_W)'(colour);
    return prod[2*LEVEL_W-1:LEVEL_W];
  endfunction

  // manual colour: field * 36 at full master
  function automatic logic [LEVEL_W-1:0] manual_level(input logic [FIELD_W-1:0] field);
    logic [LEVEL_W-1:0] colour;
    colour = MANUAL_STEP * {{(LEVEL_W-FIELD_W){1'b0}}, field};
    return scale_level(FULL_MASTER, colour);
  endfunction

endpackage

@@ src/dmxrgb_pwm.sv @@
// Three-channel 8-bit PWM generator advanced by tick transfers.
module dmxrgb_pwm
  import dmxrgb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,
  input  level_arr_t             levels,
  output logic [NUM_COLOURS-1:0] pins
);

  logic [LEVEL_W-1:0]     phase;
  logic [NUM_COLOURS-1:0] pins_next;

  always_comb begin
    for (int k = 0; k < NUM_COLOURS; k++) begin
      pins_next[k] = pins[k];
      if (phase == '0) begin
        pins_next[k] = 1'b1;
      end
      // equal-to-level wins, so a zero level never drives high
      if (phase == levels[k]) begin
        pins_next[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      pins  <= '0;
    end else if (tick) begin
      phase <= phase + 1'b1;
      pins  <= pins_next;
    end
  end

endmodule

@@ src/dmx_slot_capture_rgb_pwm.sv @@
// Top level: DMX slot capture feeding an RGB PWM generator.
//
//  channel  | signals                              | moves
//  ---------+--------------------------------------+-------------------------------
//  item     | item_valid, item_stall, item         | byte (with break) or PWM tick
//  result   | result_valid, result_stall, result   | pin levels and set_updated
//  config   | cfg_write, cfg_index, cfg_data       | base_address, dmx_mode writes
//
//  One transfer is accepted per cycle into the input register unless item_stall
//  is high; its result is then loaded into the result register and leaves from
//  there. Both registers hold one transfer, so one more transfer enters
//  while a result waits. Input stalls only when both registers are full and
//  downstream stalls.
//  Reset is synchronous: slot counter goes to 1, levels, phase and pins to 0,
//  dmx_mode to 1.
module dmx_slot_capture_rgb_pwm
  import dmxrgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_write,
  input  cfg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

`include "assert_macros.svh"

  // configuration
  logic [BASE_W-1:0] base_address;
  logic              dmx_mode;

  // input register
  logic  held_valid;
  item_t held;

  // block state
  logic [SLOT_W-1:0]              slot_counter;
  logic [SLOT_W-1:0]              slot_counter_next;
  logic [NUM_COLOURS-1:0][LEVEL_W-1:0] staged;
  level_arr_t                     levels;
  level_arr_t                     levels_next;
  level_arr_t                     manual_levels;
  level_arr_t                     active_levels;
  logic [NUM_COLOURS-1:0]         pins;

  // handshake
  logic advance;
  logic work;
  logic is_byte;
  logic tick;

  // slot window
  logic [SLOT_W:0] slot_diff;
  logic            in_window;
  logic [1:0]      slot_pos;
  logic            set_done;

  result_t result_next;

  // assertion helpers
  logic                                  out_held;
  logic                                  set_out;
  logic [SLOT_W+NUM_COLOURS*LEVEL_W-1:0] kept_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      dmx_mode     <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data[BASE_W-1:0];
        REG_DMX_MODE:     dmx_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register frees up when empty or taken this cycle
  assign advance    = !result_valid || !result_stall;
  assign item_stall = held_valid && !advance;
  assign work       = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held <= item;
    end
  end

  // manual levels come from the three 3-bit fields, red in the top bits
  always_comb begin
    for (int k = 0; k < NUM_COLOURS; k++) begin
      manual_levels[k] = manual_level(base_address[FIELD_W*(NUM_COLOURS-1-k) +: FIELD_W]);
    end
  end

  // manual mode refreshes levels on every step
  assign active_levels = dmx_mode ? levels : manual_levels;

  assign is_byte = work && (held.command == CMD_BYTE) && dmx_mode;
  assign tick    = work && (held.command == CMD_TICK);

  // position of the current slot relative to the fixture base
  assign slot_diff = {1'b0, slot_counter} - {2'b00, base_address};
  assign in_window = (slot_counter >= SLOT_W'(base_address)) && (slot_diff < (SLOT_W+1)'(4));
  assign slot_pos  = slot_diff[1:0];
  assign set_done  = is_byte && !held.break_flag && in_window && (slot_pos == 2'd3);

  always_comb begin
    slot_counter_next = slot_counter;
    if (is_byte) begin
      if (held.break_flag) begin
        slot_counter_next = '0;
      end else if (slot_counter != SLOT_MAX) begin
        slot_counter_next = slot_counter + 1'b1;
      end
    end
  end

  always_comb begin
    levels_next = active_levels;
    if (set_done) begin
      levels_next[0] = scale_level(staged[0], staged[1]);
      levels_next[1] = scale_level(staged[0], staged[2]);
      levels_next[2] = scale_level(staged[0], held.data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counter <= SLOT_W'(1);
      staged       <= '0;
      levels       <= '0;
    end else if (work) begin
      slot_counter <= slot_counter_next;
      levels       <= levels_next;
      if (is_byte && !held.break_flag && in_window && (slot_pos != 2'd3)) begin
        staged[slot_pos] <= held.data_byte;
      end
    end
  end

  dmxrgb_pwm u_pwm (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .levels (active_levels),
    .pins   (pins)
  );

  // pins report the state before this transfer's tick
  always_comb begin
    result_next.red_on      = pins[0];
    result_next.green_on    = pins[1];
    result_next.blue_on     = pins[2];
    result_next.set_updated = set_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      result <= result_next;
    end
  end

  assign out_held   = result_valid && result_stall;
  assign set_out    = result_valid && result.set_updated;
  assign kept_state = {slot_counter, levels};

  `CHECK_RST(a_stall_needs_full_out, clk, rst, item_stall |-> out_held, "stall with free output")
  `CHECK_RST(a_state_holds_on_stall, clk, rst, out_held |=> $stable(kept_state), "state moved")
  `CHECK_RST(a_update_reported, clk, rst, set_done |=> set_out, "completed set not reported")

endmodule
